>>> hdl/ps2md_pkg.sv
// ps2md_pkg: shared types and constants for the ps2 mouse packet decoder
// no dependencies; imported by every module of the decoder

package ps2md_pkg;

	localparam int BYTE_W   = 8;
	localparam int LIMIT_W  = 11;
	localparam int BUTTON_W = 5;
	localparam int WHEEL_W  = 4;
	localparam int COUNT_W  = 32;
	localparam int CFG_IDX_W = 2;

	// bit positions inside the received bytes
	localparam int START_BIT   = 3;
	localparam int BACK_BIT    = 4;
	localparam int FORWARD_BIT = 5;

	localparam logic [LIMIT_W-1:0] WIDTH_RESET  = 11'd80;
	localparam logic [LIMIT_W-1:0] HEIGHT_RESET = 11'd25;
	localparam int CURSOR_X_RESET = 40;
	localparam int CURSOR_Y_RESET = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLED       = 2'd0,
		CFG_WHEEL_MODE    = 2'd1,
		CFG_SCREEN_WIDTH  = 2'd2,
		CFG_SCREEN_HEIGHT = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic               enabled;
		logic               wheel_mode;
		logic [LIMIT_W-1:0] screen_width;
		logic [LIMIT_W-1:0] screen_height;
	} cfg_t;

	// a completed packet as seen by the report logic
	typedef struct packed {
		logic              complete;
		logic              wheel;
		logic [BYTE_W-1:0] b0;
		logic [BYTE_W-1:0] b1;
		logic [BYTE_W-1:0] b2;
		logic [BYTE_W-1:0] b3;
	} packet_t;

endpackage

>>> hdl/ps2md_clamp.sv
// ps2md_clamp: adds a signed byte delta to one cursor coordinate and clamps it
// to the screen limit; depends on ps2md_pkg

module ps2md_clamp import ps2md_pkg::*; #(
	parameter int POSITION_BITS = 10
) (
	input  logic [POSITION_BITS-1:0] cur,
	input  logic signed [BYTE_W-1:0] delta,
	input  logic [LIMIT_W-1:0]       limit,
	output logic [POSITION_BITS-1:0] nxt
);

	localparam int LW = (POSITION_BITS + 1 > LIMIT_W) ? POSITION_BITS + 1 : LIMIT_W;
	localparam int VW = POSITION_BITS + 2;
	localparam logic [LW-1:0] LIM_MAX = LW'({1'b1, {POSITION_BITS{1'b0}}});
	localparam logic [LW-1:0] LIM_ONE = LW'(1);

	logic [LW-1:0]            lim_raw;
	logic [LW-1:0]            lim;
	logic [POSITION_BITS-1:0] top;
	logic signed [VW-1:0]     sum;
	logic signed [VW-1:0]     top_ext;

	always_comb begin
		lim_raw = LW'(limit);
		// zero acts as one, oversize saturates to the coordinate range
		priority if (lim_raw == '0) begin
			lim = LIM_ONE;
		end else if (lim_raw > LIM_MAX) begin
			lim = LIM_MAX;
		end else begin
			lim = lim_raw;
		end
		top     = POSITION_BITS'(lim - LIM_ONE);
		top_ext = $signed({2'b00, top});
		sum     = $signed({2'b00, cur}) + $signed({{(VW-BYTE_W){delta[BYTE_W-1]}}, delta});
		priority if (sum[VW-1]) begin
			nxt = '0;
		end else if (sum > top_ext) begin
			nxt = top;
		end else begin
			nxt = POSITION_BITS'(sum);
		end
	end

endmodule

>>> hdl/ps2md_assembler.sv
// ps2md_assembler: byte position counter and held packet bytes
// depends on ps2md_pkg

module ps2md_assembler import ps2md_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              item_valid,
	input  logic [BYTE_W-1:0] item_byte,
	input  logic              advance,
	output packet_t           pkt
);

	logic [1:0]        pos_q;
	logic [BYTE_W-1:0] held_q [3];
	logic [1:0]        eff_pos;
	logic              start;
	logic              take;
	logic              last;

	always_comb begin
		start   = item_byte[START_BIT];
		// a flagged byte in mid-packet restarts the packet
		eff_pos = (pos_q != 2'd0 && start) ? 2'd0 : pos_q;
		take    = cfg.enabled && !(eff_pos == 2'd0 && !start);
		last    = cfg.wheel_mode ? (eff_pos == 2'd3) : (eff_pos >= 2'd2);

		pkt.complete = item_valid && take && last;
		pkt.wheel    = cfg.wheel_mode;
		pkt.b0       = held_q[0];
		pkt.b1       = held_q[1];
		pkt.b2       = (eff_pos == 2'd2) ? item_byte : held_q[2];
		pkt.b3       = item_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
		end else if (advance && take) begin
			pos_q <= last ? 2'd0 : eff_pos + 2'd1;
		end
	end

	// no reset: each entry is written before the packet reads it
	always_ff @(posedge clk) begin
		if (advance && take && eff_pos != 2'd3) begin
			held_q[eff_pos] <= item_byte;
		end
	end

`ifndef SYNTHESIS
	a_disabled_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg.enabled |=> $stable(pos_q))
		else $error("byte position moved while disabled");
`endif

endmodule

>>> hdl/ps2md_report.sv
// ps2md_report: cursor, button history and packet count; builds one report
// per completed packet; depends on ps2md_pkg and ps2md_clamp

module ps2md_report import ps2md_pkg::*; #(
	parameter int POSITION_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  packet_t                    pkt,
	input  logic                       commit,
	output logic [POSITION_BITS-1:0]   pos_x,
	output logic [POSITION_BITS-1:0]   pos_y,
	output logic signed [BYTE_W-1:0]   delta_x,
	output logic signed [BYTE_W-1:0]   delta_y,
	output logic signed [WHEEL_W-1:0]  delta_wheel,
	output logic [BUTTON_W-1:0]        button_state,
	output logic [BUTTON_W-1:0]        pressed_buttons,
	output logic [BUTTON_W-1:0]        released_buttons,
	output logic                       moved,
	output logic [COUNT_W-1:0]         report_count
);

	logic [POSITION_BITS-1:0] cursor_x_q;
	logic [POSITION_BITS-1:0] cursor_y_q;
	logic [BUTTON_W-1:0]      last_buttons_q;
	logic [COUNT_W-1:0]       total_q;

	assign delta_x = $signed(pkt.b1);
	assign delta_y = $signed(pkt.b2);

	ps2md_clamp #(.POSITION_BITS(POSITION_BITS)) u_clamp_x (
		.cur   (cursor_x_q),
		.delta (delta_x),
		.limit (cfg.screen_width),
		.nxt   (pos_x)
	);

	ps2md_clamp #(.POSITION_BITS(POSITION_BITS)) u_clamp_y (
		.cur   (cursor_y_q),
		.delta (delta_y),
		.limit (cfg.screen_height),
		.nxt   (pos_y)
	);

	always_comb begin
		delta_wheel      = pkt.wheel ? $signed(pkt.b3[WHEEL_W-1:0]) : '0;
		button_state     = {pkt.wheel & pkt.b3[FORWARD_BIT], pkt.wheel & pkt.b3[BACK_BIT],
			pkt.b0[2:0]};
		pressed_buttons  = button_state & ~last_buttons_q;
		released_buttons = last_buttons_q & ~button_state;
		moved            = (pos_x != cursor_x_q) || (pos_y != cursor_y_q) ||
			(delta_x != '0) || (delta_y != '0);
		report_count     = total_q + COUNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q     <= POSITION_BITS'(CURSOR_X_RESET);
			cursor_y_q     <= POSITION_BITS'(CURSOR_Y_RESET);
			last_buttons_q <= '0;
			total_q        <= '0;
		end else if (commit) begin
			cursor_x_q     <= pos_x;
			cursor_y_q     <= pos_y;
			last_buttons_q <= button_state;
			total_q        <= report_count;
		end
	end

`ifndef SYNTHESIS
	a_state_only_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(total_q) && $stable(last_buttons_q) &&
			$stable(cursor_x_q) && $stable(cursor_y_q))
		else $error("report state changed without a packet");
	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> total_q == $past(total_q) + COUNT_W'(1))
		else $error("packet count did not step by one");
`endif

endmodule

>>> hdl/ps2_mouse_packet_decoder.sv
// ps2_mouse_packet_decoder: top level of the ps2 mouse packet decoder
// depends on ps2md_pkg, ps2md_assembler, ps2md_report, ps2md_clamp
//
//  channel   dir  payload                                            transfer
//  s_axis    in   rx_byte                                            tvalid & tready
//  m_axis    out  one report per completed packet                    tvalid & tready
//  cfg       in   enabled, wheel_mode, screen_width, screen_height   cfg_we
//
// one byte per clock sustained while no completed packet waits behind an unread
// report: a byte is held in the input register, where the packet assembly and
// the cursor update run, then its report (if any) lands in the result register
// the result register lets the next byte in while a report waits to be taken;
// only a byte that completes a packet waits behind an unread report
// asynchronous active-low reset clears control state, cursor to 40,12,
// screen to 80 by 25, decoder disabled

module ps2_mouse_packet_decoder import ps2md_pkg::*; #(
	parameter int POSITION_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input byte stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,   // rx_byte
	// report stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// from bit 0 up: pos_x, pos_y, delta_x, delta_y, delta_wheel, button_state,
	// pressed_buttons, released_buttons, moved, report_count, zero fill
	output logic [((2*POSITION_BITS+68+7)/8)*8-1:0] m_axis_tdata,
	// configuration writes
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [LIMIT_W-1:0]     cfg_data
);

	localparam int OUT_BITS = 2*POSITION_BITS + 68;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled       <= 1'b0;
			cfg_q.wheel_mode    <= 1'b0;
			cfg_q.screen_width  <= WIDTH_RESET;
			cfg_q.screen_height <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_ENABLED:       cfg_q.enabled       <= cfg_data[0];
				CFG_WHEEL_MODE:    cfg_q.wheel_mode    <= cfg_data[0];
				CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data;
				CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data;
			endcase
		end
	end

	// input register
	logic              s1_valid_q;
	logic [BYTE_W-1:0] byte_s1;
	logic              s1_fire;
	logic              commit;
	logic              in_xfer;
	packet_t           pkt;

	// result register
	logic               out_valid_q;
	logic [OUT_BITS-1:0] out_data_q;

	// a byte that finishes a packet needs a free result slot, any other
	// byte just updates the assembly state
	assign s1_fire       = s1_valid_q && (!pkt.complete || !out_valid_q || m_axis_tready);
	assign commit        = s1_fire && pkt.complete;
	assign s_axis_tready = !s1_valid_q || s1_fire;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_xfer) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	ps2md_assembler u_assembler (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (s1_valid_q),
		.item_byte  (byte_s1),
		.advance    (s1_fire),
		.pkt        (pkt)
	);

	logic [POSITION_BITS-1:0]  pos_x;
	logic [POSITION_BITS-1:0]  pos_y;
	logic signed [BYTE_W-1:0]  delta_x;
	logic signed [BYTE_W-1:0]  delta_y;
	logic signed [WHEEL_W-1:0] delta_wheel;
	logic [BUTTON_W-1:0]       button_state;
	logic [BUTTON_W-1:0]       pressed_buttons;
	logic [BUTTON_W-1:0]       released_buttons;
	logic                      moved;
	logic [COUNT_W-1:0]        report_count;

	ps2md_report #(.POSITION_BITS(POSITION_BITS)) u_report (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.pkt              (pkt),
		.commit           (commit),
		.pos_x            (pos_x),
		.pos_y            (pos_y),
		.delta_x          (delta_x),
		.delta_y          (delta_y),
		.delta_wheel      (delta_wheel),
		.button_state     (button_state),
		.pressed_buttons  (pressed_buttons),
		.released_buttons (released_buttons),
		.moved            (moved),
		.report_count     (report_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_data_q <= {report_count, moved, released_buttons, pressed_buttons,
				button_state, delta_wheel, delta_y, delta_x, pos_y, pos_x};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_data_q);

`ifndef SYNTHESIS
	a_report_presented: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> m_axis_tvalid)
		else $error("completed packet did not reach the result register");
	a_byte_kept: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_fire |=> s1_valid_q && $stable(byte_s1))
		else $error("stalled byte lost from the input register");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> !out_valid_q || m_axis_tready)
		else $error("report written over an unread one");
`endif

endmodule

>>> tb/sv/ps2_mouse_packet_decoder_tb.sv
// ps2_mouse_packet_decoder_tb: self-checking bench for the ps2 mouse packet decoder
// feeds byte streams under several screen and mode settings and checks each report
// depends on ps2md_pkg and ps2_mouse_packet_decoder

module ps2_mouse_packet_decoder_tb import ps2md_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POS_BITS       = 10;
	localparam int TDATA_W        = ((2*POS_BITS+68+7)/8)*8;
	localparam int RESET_CYCLES   = 6;
	localparam int LATENCY_SLACK  = 8;     // margin for a byte to pass both registers
	localparam int LONG_HOLD      = 400;   // receiver back-pressure stretch
	localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transfer or write

	// one report as packed on m_axis_tdata, first member is the top bits
	typedef struct packed {
		logic [COUNT_W-1:0]        count;
		logic                      moved;
		logic [BUTTON_W-1:0]       released;
		logic [BUTTON_W-1:0]       pressed;
		logic [BUTTON_W-1:0]       buttons;
		logic signed [WHEEL_W-1:0] wheel;
		logic signed [7:0]         dy;
		logic signed [7:0]         dx;
		logic [POS_BITS-1:0]       y;
		logic [POS_BITS-1:0]       x;
	} report_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata = 8'h00;   // rx_byte
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	// from bit 0 up: pos_x, pos_y, delta_x, delta_y, delta_wheel, button_state,
	// pressed_buttons, released_buttons, moved, report_count
	logic [TDATA_W-1:0]   m_axis_tdata;
	logic                 cfg_we = 1'b0;
	cfg_index_t           cfg_index = CFG_ENABLED;
	logic [LIMIT_W-1:0]   cfg_data = '0;

	ps2_mouse_packet_decoder #(
		.POSITION_BITS(POS_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// stimulus and scoreboard storage
	logic [7:0] pending_bytes[$];
	report_t    expected_reports[$];
	int         bytes_queued = 0;
	int         bytes_consumed = 0;
	int         mismatches = 0;
	logic       rx_accepted = 1'b0;
	int         quiet_cycles = 0;

	// idling knobs, percent of cycles
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// long receiver hold: the stimulus bumps the trigger, the receiver counts it out
	int hold_trigger = 0;
	int hold_seen = 0;
	int hold_left = 0;

	// decoder mirror: register copies
	logic               mirror_enabled = 1'b0;
	logic               mirror_wheel = 1'b0;
	logic [LIMIT_W-1:0] mirror_width = WIDTH_RESET;
	logic [LIMIT_W-1:0] mirror_height = HEIGHT_RESET;

	// decoder mirror: packet assembly and cursor state
	logic [1:0]          asm_slot = 2'd0;
	logic [7:0]          asm_bytes[3];
	logic [POS_BITS-1:0] cur_x = POS_BITS'(CURSOR_X_RESET);
	logic [POS_BITS-1:0] cur_y = POS_BITS'(CURSOR_Y_RESET);
	logic [BUTTON_W-1:0] prev_buttons = '0;
	logic [COUNT_W-1:0]  packet_total = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	// move one axis and clamp it into the screen; zero size acts as one,
	// sizes past the position range saturate to it
	function automatic logic [POS_BITS-1:0] clamp_axis(input logic [POS_BITS-1:0] cur,
			input int delta, input logic [LIMIT_W-1:0] lim);
		int span;
		int v;
		span = (lim == '0) ? 1 : int'(lim);
		if (span > (1 << POS_BITS)) span = 1 << POS_BITS;
		v = int'(cur) + delta;
		if (v < 0) v = 0;
		if (v > span - 1) v = span - 1;
		return POS_BITS'(v);
	endfunction

	// take one byte into the packet mirror; returns 1 with the report when
	// the byte completes a packet
	function automatic bit decode_byte(input logic [7:0] b, output report_t r);
		logic [1:0]          slot;
		logic [BUTTON_W-1:0] btn;
		int                  dx;
		int                  dy;
		logic [POS_BITS-1:0] nx;
		logic [POS_BITS-1:0] ny;
		r = '0;
		slot = asm_slot;
		if (!mirror_enabled) return 1'b0;
		// waiting for a first byte: only a byte with the start bit counts
		if (slot == 2'd0 && !b[START_BIT]) return 1'b0;
		// start bit in a later byte throws away the partial packet
		if (slot != 2'd0 && b[START_BIT]) slot = 2'd0;
		if (mirror_wheel ? (slot != 2'd3) : (slot < 2'd2)) begin
			asm_bytes[slot] = b;
			asm_slot = slot + 2'd1;
			return 1'b0;
		end
		// three held bytes after leaving wheel mode: this byte only closes the packet
		if (slot < 2'd3) asm_bytes[slot] = b;
		asm_slot = 2'd0;

		dx = $signed(asm_bytes[1]);
		dy = $signed(asm_bytes[2]);
		btn = {2'b00, asm_bytes[0][2:0]};
		if (mirror_wheel) begin
			r.wheel = b[WHEEL_W-1:0];
			btn[3] = b[BACK_BIT];
			btn[4] = b[FORWARD_BIT];
		end
		nx = clamp_axis(cur_x, dx, mirror_width);
		ny = clamp_axis(cur_y, dy, mirror_height);
		r.moved = (nx != cur_x) || (ny != cur_y) || (dx != 0) || (dy != 0);
		r.x = nx;
		r.y = ny;
		r.dx = asm_bytes[1];
		r.dy = asm_bytes[2];
		r.buttons = btn;
		r.pressed = btn & ~prev_buttons;
		r.released = prev_buttons & ~btn;
		packet_total = packet_total + 1'b1;
		r.count = packet_total;
		cur_x = nx;
		cur_y = ny;
		prev_buttons = btn;
		return 1'b1;
	endfunction

	function automatic void check_field(input string fname, input longint want,
			input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", fname, want, got);
			mismatches++;
		end
	endfunction

	// byte driver: changes on the falling edge, holds a byte until its transfer
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || rx_accepted)) begin
			if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_bytes.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// report receiver: random stalls plus the occasional long hold
	always @(negedge clk) begin
		if (hold_trigger != hold_seen) begin
			hold_seen <= hold_trigger;
			hold_left <= LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: checks each report transfer, predicts on each byte transfer,
	// and runs the watchdog
	always @(posedge clk) begin : monitor
		report_t got;
		report_t want;
		report_t fresh;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = report_t'(m_axis_tdata);
				if (expected_reports.size() == 0) begin
					$error("report transfer with nothing expected: count %0d", got.count);
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					check_field("pos_x", want.x, got.x);
					check_field("pos_y", want.y, got.y);
					check_field("delta_x", want.dx, got.dx);
					check_field("delta_y", want.dy, got.dy);
					check_field("delta_wheel", want.wheel, got.wheel);
					check_field("button_state", want.buttons, got.buttons);
					check_field("pressed_buttons", want.pressed, got.pressed);
					check_field("released_buttons", want.released, got.released);
					check_field("moved", want.moved, got.moved);
					check_field("report_count", want.count, got.count);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				bytes_consumed++;
				if (decode_byte(s_axis_tdata, fresh)) expected_reports.push_back(fresh);
			end
		end
		rx_accepted <= arst_n && s_axis_tvalid && s_axis_tready;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// register write while the decoder is idle; the mirror follows on the same edge
	task automatic set_reg(input cfg_index_t idx, input logic [LIMIT_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_ENABLED:       mirror_enabled = val[0];
			CFG_WHEEL_MODE:    mirror_wheel = val[0];
			CFG_SCREEN_WIDTH:  mirror_width = val;
			CFG_SCREEN_HEIGHT: mirror_height = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_byte(input logic [7:0] b);
		pending_bytes.push_back(b);
		bytes_queued++;
	endtask

	// movement or wheel byte that does not restart the packet; often small
	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		if ($urandom_range(99) < 40) begin
			b = $urandom_range(1) ? 8'($urandom_range(7)) : 8'(8'hF0 + $urandom_range(7));
		end else begin
			b = 8'($urandom_range(255));
		end
		b[START_BIT] = 1'b0;
		return b;
	endfunction

	// mostly whole packets with random content, some cut short, some noise
	task automatic add_random(input int n, input bit wheel);
		int         made;
		int         kind;
		int         plen;
		int         cut;
		int         noise;
		logic [7:0] b;
		made = 0;
		plen = wheel ? 4 : 3;
		while (made < n) begin
			kind = $urandom_range(99);
			if (kind < 82) begin
				cut = (kind < 72) ? plen : $urandom_range(plen - 1, 1);
				b = 8'($urandom_range(255));
				b[START_BIT] = 1'b1;
				queue_byte(b);
				for (int i = 1; i < cut; i++) queue_byte(body_byte());
				made += cut;
			end else begin
				noise = $urandom_range(3, 1);
				repeat (noise) queue_byte(8'($urandom_range(255)));
				made += noise;
			end
		end
	endtask

	// wait until every byte is taken and every report is in, then let the
	// pipeline settle so a byte without a report is surely through
	task automatic drain();
		while (bytes_consumed != bytes_queued || expected_reports.size() != 0) @(posedge clk);
		repeat (LATENCY_SLACK) @(posedge clk);
	endtask

	task automatic run_phase(input logic en, input logic wh, input logic [LIMIT_W-1:0] w,
			input logic [LIMIT_W-1:0] h, input int send_pct, input int recv_pct,
			input int n, input bit press);
		set_reg(CFG_ENABLED, en);
		set_reg(CFG_WHEEL_MODE, wh);
		set_reg(CFG_SCREEN_WIDTH, w);
		set_reg(CFG_SCREEN_HEIGHT, h);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		if (press) hold_trigger++;
		add_random(n, wh);
		drain();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// still disabled from reset: a would-be packet start is dropped
		queue_byte(8'h08); queue_byte(8'h00);
		drain();

		set_reg(CFG_ENABLED, 1'b1);
		// bytes without the start bit while waiting for a first byte
		queue_byte(8'h00); queue_byte(8'hF7);
		// all buttons, most negative deltas: clamps to the origin
		queue_byte(8'h0F); queue_byte(8'h80); queue_byte(8'h80);
		// largest positive deltas that keep the start bit clear: clamps to the far edge
		queue_byte(8'h08); queue_byte(8'h77); queue_byte(8'h77);
		// all-ones first byte, no movement, buttons pressed against the last packet
		queue_byte(8'hFF); queue_byte(8'h00); queue_byte(8'h00);
		// restart after one byte
		queue_byte(8'h09); queue_byte(8'h1A); queue_byte(8'h00); queue_byte(8'h00);
		// leave two bytes held
		queue_byte(8'h0A); queue_byte(8'h01);
		drain();

		// wheel mode switched on with two bytes held: two more complete the packet
		set_reg(CFG_WHEEL_MODE, 1'b1);
		queue_byte(8'h02); queue_byte(8'h37);
		// wheel byte with the start bit restarts, then three bytes stay held
		queue_byte(8'h0C); queue_byte(8'h01); queue_byte(8'h02); queue_byte(8'h28);
		queue_byte(8'h01); queue_byte(8'h02);
		drain();

		// wheel mode cleared with three held: the next byte closes the packet unused
		set_reg(CFG_WHEEL_MODE, 1'b0);
		queue_byte(8'h55);
		drain();

		// random phases: settings from reset values to the extremes, idling in turn
		run_phase(1'b1, 1'b0, 11'd80, 11'd25, 0, 0, 240, 1'b0);
		run_phase(1'b1, 1'b1, 11'd1024, 11'd1024, 53, 0, 240, 1'b0);
		run_phase(1'b1, 1'b0, 11'd1, 11'd1, 0, 53, 240, 1'b0);
		run_phase(1'b1, 1'b1, 11'd0, 11'd2047, 36, 36, 240, 1'b0);
		// disabled: bytes dropped, a partial packet survives
		run_phase(1'b0, 1'b1, 11'd0, 11'd2047, 0, 0, 30, 1'b0);
		// long receiver hold with a busy sender so the input backs up
		run_phase(1'b1, 1'b1, 11'd640, 11'd480, 0, 0, 240, 1'b1);
		run_phase(1'b1, 1'b0, 11'd1023, 11'd1025, 53, 0, 240, 1'b0);
		// much smaller screen: the cursor starts outside and gets pulled in
		run_phase(1'b1, 1'b1, 11'd7, 11'd3, 0, 53, 240, 1'b0);
		run_phase(1'b1, 1'b0, 11'd1024, 11'd1, 36, 36, 240, 1'b0);

		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
